FILE: src/mgs3_pkg.sv
// Shared types, constants and tables for the masked 3x3 Gaussian smoother.
package mgs3_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALID    = 2'd2;

    localparam int DIM_W  = 11;
    localparam int MINV_W = 4;
    localparam logic [DIM_W-1:0]  WIDTH_RESET     = 11'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 11'd480;
    localparam logic [MINV_W-1:0] MIN_VALID_RESET = 4'd6;
    localparam int MIN_DIM = 3;

    // Datapath widths
    localparam int PIX_W     = 16;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int SUM_W     = 20;
    localparam int CNT_W     = 4;
    localparam int QUO_W     = 19;
    localparam int RECIP_W   = 21;
    localparam int RECIP_SHIFT = 20;
    localparam int WIN_SIZE  = 9;

    localparam logic [PIX_W-1:0] MISSING_VALUE = 16'hFF00;
    localparam logic [PIX_W-1:0] DRAIN_VALUE   = 16'hFFFF;
    localparam logic [PIX_W-1:0] SAT_VALUE     = 16'h7FFF;
    localparam logic [QUO_W-1:0] SAT_LIMIT     = 19'd32767;

    // Window geometry: row and column of each tap, and the log2 of its weight.
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_LAST  = 2'd2;
    localparam logic [1:0] WIN_ROW [0:WIN_SIZE-1] =
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] WIN_COL [0:WIN_SIZE-1] =
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] WIN_SHIFT [0:WIN_SIZE-1] =
        '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0};

    typedef struct packed {
        logic have_out;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } pos_flags_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             flag;
        logic             last;
    } sum_stage_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] value;
        logic             flag;
        logic             last;
    } result_t;

    // floor(2^20 / n); the estimate it gives is at most one below the true quotient.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            unique case (n)
                4'd1:    r = 21'd1048576;
                4'd2:    r = 21'd524288;
                4'd3:    r = 21'd349525;
                4'd4:    r = 21'd262144;
                4'd5:    r = 21'd209715;
                4'd6:    r = 21'd174762;
                4'd7:    r = 21'd149796;
                4'd8:    r = 21'd131072;
                4'd9:    r = 21'd116508;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: src/mgs3_line_store.sv
// Line store memory: one word per column holding the two previous lines.
module mgs3_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/mgs3_window_sum.sv
// 3x3 window registers and the masked weighted sum and usable count stage.
module mgs3_window_sum (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [mgs3_pkg::PIX_W-1:0]      top,
    input  logic [mgs3_pkg::PIX_W-1:0]      mid,
    input  logic [mgs3_pkg::PIX_W-1:0]      px,
    input  mgs3_pkg::pos_flags_t            pos,
    input  logic [mgs3_pkg::MINV_W-1:0]     min_valid,
    output mgs3_pkg::sum_stage_t            sum_out
);

    logic [mgs3_pkg::PIX_W-1:0] win_reg [0:mgs3_pkg::WIN_SIZE-1];
    logic                       s2_valid_reg;
    mgs3_pkg::pos_flags_t       s2_pos_reg;
    mgs3_pkg::sum_stage_t       s3_reg;

    logic [mgs3_pkg::WIN_SIZE-1:0] usable;
    logic [mgs3_pkg::SUM_W-1:0]    sum_c;
    logic [mgs3_pkg::CNT_W-1:0]    cnt_c;
    logic [mgs3_pkg::MINV_W-1:0]   mv_c;

    // The newest column enters on the right; every item shifts the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mgs3_pkg::WIN_SIZE; k++)
            begin
                win_reg[k] <= '0;
            end
            s2_valid_reg <= 1'b0;
            s2_pos_reg   <= '0;
        end
        else if (en)
        begin
            if (in_valid)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= top;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= mid;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= px;
            end
            s2_valid_reg <= in_valid && pos.have_out;
            s2_pos_reg   <= pos;
        end
    end

    always_comb
    begin
        for (int k = 0; k < mgs3_pkg::WIN_SIZE; k++)
        begin
            usable[k] = !win_reg[k][mgs3_pkg::PIX_W-1]
                && !(mgs3_pkg::WIN_ROW[k] == mgs3_pkg::POS_FIRST && !s2_pos_reg.top_ok)
                && !(mgs3_pkg::WIN_ROW[k] == mgs3_pkg::POS_LAST && !s2_pos_reg.bot_ok)
                && !(mgs3_pkg::WIN_COL[k] == mgs3_pkg::POS_FIRST && !s2_pos_reg.left_ok)
                && !(mgs3_pkg::WIN_COL[k] == mgs3_pkg::POS_LAST && !s2_pos_reg.right_ok);
        end
    end

    always_comb
    begin
        sum_c = '0;
        cnt_c = '0;
        for (int k = 0; k < mgs3_pkg::WIN_SIZE; k++)
        begin
            if (usable[k])
            begin
                sum_c = sum_c + (mgs3_pkg::SUM_W'(win_reg[k]) << mgs3_pkg::WIN_SHIFT[k]);
                cnt_c = cnt_c + 1'b1;
            end
        end
        mv_c = (min_valid == '0) ? mgs3_pkg::MINV_W'(1) : min_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (en)
        begin
            s3_reg.valid <= s2_valid_reg;
            s3_reg.sum   <= sum_c;
            s3_reg.count <= cnt_c;
            s3_reg.flag  <= cnt_c < mv_c;
            s3_reg.last  <= s2_pos_reg.last;
        end
    end

    assign sum_out = s3_reg;

endmodule

FILE: src/mgs3_scale.sv
// Normalization pipeline: sum x9/16, divide by count via reciprocal, saturate.
module mgs3_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  mgs3_pkg::sum_stage_t sum_in,
    output mgs3_pkg::result_t    result
);

    localparam int PROD_W = mgs3_pkg::QUO_W + mgs3_pkg::RECIP_W;
    localparam int NPROD_W = mgs3_pkg::QUO_W + mgs3_pkg::CNT_W;

    // Stage D: scaled sum and reciprocal lookup
    logic                         d_valid_reg;
    logic [mgs3_pkg::QUO_W-1:0]   d_q_reg;
    logic [mgs3_pkg::CNT_W-1:0]   d_n_reg;
    logic [mgs3_pkg::RECIP_W-1:0] d_recip_reg;
    logic                         d_flag_reg;
    logic                         d_last_reg;
    // Stage E: quotient estimate
    logic                         e_valid_reg;
    logic [mgs3_pkg::QUO_W-1:0]   e_q_reg;
    logic [mgs3_pkg::QUO_W-1:0]   e_qe_reg;
    logic [mgs3_pkg::CNT_W-1:0]   e_n_reg;
    logic                         e_flag_reg;
    logic                         e_last_reg;

    logic [mgs3_pkg::SUM_W+3:0]   sum9;
    logic [PROD_W-1:0]            prod;
    logic [NPROD_W-1:0]           back_prod;
    logic [mgs3_pkg::QUO_W-1:0]   rem;
    logic [mgs3_pkg::QUO_W-1:0]   quo;

    // floor(floor(9*sum/16)/n) equals floor(9*sum/(16*n)).
    assign sum9 = {sum_in.sum, 3'b000} + (mgs3_pkg::SUM_W+4)'(sum_in.sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= sum_in.valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_q_reg     <= sum9[mgs3_pkg::SUM_W+2:4];
            d_n_reg     <= sum_in.count;
            d_recip_reg <= mgs3_pkg::recip(sum_in.count);
            d_flag_reg  <= sum_in.flag;
            d_last_reg  <= sum_in.last;
            e_q_reg     <= d_q_reg;
            e_qe_reg    <= prod[mgs3_pkg::RECIP_SHIFT +: mgs3_pkg::QUO_W];
            e_n_reg     <= d_n_reg;
            e_flag_reg  <= d_flag_reg;
            e_last_reg  <= d_last_reg;
        end
    end

    assign prod = PROD_W'(d_q_reg) * PROD_W'(d_recip_reg);

    // The estimate is low by at most one; the remainder tells which.
    always_comb
    begin
        back_prod = NPROD_W'(e_qe_reg) * NPROD_W'(e_n_reg);
        rem       = e_q_reg - back_prod[mgs3_pkg::QUO_W-1:0];
        quo       = (rem >= mgs3_pkg::QUO_W'(e_n_reg)) ? e_qe_reg + 1'b1 : e_qe_reg;
        result.valid = e_valid_reg;
        result.flag  = e_flag_reg;
        result.last  = e_last_reg;
        priority if (e_flag_reg)
        begin
            result.value = mgs3_pkg::MISSING_VALUE;
        end
        else if (quo > mgs3_pkg::SAT_LIMIT)
        begin
            result.value = mgs3_pkg::SAT_VALUE;
        end
        else
        begin
            result.value = quo[mgs3_pkg::PIX_W-1:0];
        end
    end

endmodule

FILE: src/masked_gaussian_3x3_smoother_unit.sv
// Top level of the masked 3x3 Gaussian smoother with line store and output register.
//
// Pixels arrive in raster order on the pixel channel (pixel_valid, pixel_stall,
// kind, pixel_value); a transfer happens when pixel_valid is high and pixel_stall
// low. Smoothed pixels leave on the result channel (result_valid, result_stall)
// with filtered_value, missing_flag and frame_end. In stream terms results lag
// inputs by image_width+1 items, and the source closes each frame with
// image_width+1 drain items (kind = 1). In clock terms a result passes the s1,
// window, sum, D, E and output registers. One pixel is taken per cycle unless
// a stalled result holds the pipeline: the line store is a single-port-write,
// single-port-read memory accessed once per item, and a same-column access in
// consecutive cycles is served by forwarding the word just written.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle, a
// rule for the user, not enforced by the block; writing the width or height
// restarts the frame position. Reset clears the position counters, the window
// and all valid bits and loads the default registers; line store contents are
// left undefined, as a word read before it is written within a frame only
// feeds masked taps, so there is no clearing pass. While a result waits under
// result_stall the whole pipeline holds and pixel_stall is raised.
module masked_gaussian_3x3_smoother_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mgs3_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mgs3_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  logic                                  kind,
    input  logic signed [mgs3_pkg::PIX_W-1:0]     pixel_value,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [mgs3_pkg::PIX_W-1:0]     filtered_value,
    output logic                                  missing_flag,
    output logic                                  frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_A = (WD_W > ROW_W) ? WD_W : ROW_W;
    localparam int CMP_W = ((CMP_A > mgs3_pkg::DIM_W) ? CMP_A : mgs3_pkg::DIM_W) + 1;
    localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAXH_C = CMP_W'(MAX_HEIGHT);

    function automatic logic [CMP_W-1:0] clamp_dim(
        input logic [mgs3_pkg::DIM_W-1:0] v,
        input logic [CMP_W-1:0]           hi
    );
        logic [CMP_W-1:0] ve;
        begin
            ve = CMP_W'(v);
            priority if (ve < CMP_W'(mgs3_pkg::MIN_DIM))
            begin
                return CMP_W'(mgs3_pkg::MIN_DIM);
            end
            else if (ve > hi)
            begin
                return hi;
            end
            else
            begin
                return ve;
            end
        end
    endfunction

    // Configuration and frame position
    logic [CMP_W-1:0]             width_reg;
    logic [CMP_W-1:0]             height_reg;
    logic [mgs3_pkg::MINV_W-1:0]  min_valid_reg;
    logic [COL_W-1:0]             col_reg;
    logic [ROW_W-1:0]             row_reg;

    logic [CMP_W-1:0] col_e, row_e, c0, r0, cc, rc;
    logic [CMP_W-1:0] col_next, row_next;
    logic             restart;
    mgs3_pkg::pos_flags_t pos_a;

    // Stage between the line store read and the window
    logic                          s1_valid_reg;
    logic [COL_W-1:0]              s1_addr_reg;
    logic [mgs3_pkg::PIX_W-1:0]    s1_px_reg;
    mgs3_pkg::pos_flags_t          s1_pos_reg;
    logic                          fwd_hit_reg;
    logic [mgs3_pkg::LINE_W-1:0]   fwd_data_reg;

    logic                          en;
    logic                          accept;
    logic [mgs3_pkg::LINE_W-1:0]   rd_data;
    logic [mgs3_pkg::LINE_W-1:0]   line_word;
    logic                          wr_en;
    logic [mgs3_pkg::LINE_W-1:0]   wr_data;
    logic [mgs3_pkg::PIX_W-1:0]    px_a;

    mgs3_pkg::sum_stage_t          sum_stage;
    mgs3_pkg::result_t             scaled;

    logic                          result_valid_reg;
    logic [mgs3_pkg::PIX_W-1:0]    value_reg;
    logic                          flag_reg;
    logic                          last_reg;

    assign en          = !result_valid_reg || !result_stall;
    assign pixel_stall = !en;
    assign accept      = pixel_valid && en;

    always_comb
    begin
        col_e   = CMP_W'(col_reg);
        row_e   = CMP_W'(row_reg);
        restart = (col_e >= width_reg) || (row_e > height_reg + 1'b1);
        c0      = restart ? '0 : col_e;
        r0      = restart ? '0 : row_e;

        pos_a.have_out = (r0 >= CMP_W'(2)) || (r0 == CMP_W'(1) && c0 != '0);
        if (c0 == '0)
        begin
            cc = width_reg - 1'b1;
            rc = r0 - CMP_W'(2);
        end
        else
        begin
            cc = c0 - 1'b1;
            rc = r0 - 1'b1;
        end
        pos_a.top_ok   = rc != '0;
        pos_a.bot_ok   = (rc + 1'b1) < height_reg;
        pos_a.left_ok  = cc != '0;
        pos_a.right_ok = (cc + 1'b1) < width_reg;
        pos_a.last     = pos_a.have_out && (rc == height_reg - 1'b1)
                         && (cc == width_reg - 1'b1);

        priority if (pos_a.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c0 + 1'b1 >= width_reg)
        begin
            col_next = '0;
            row_next = r0 + 1'b1;
        end
        else
        begin
            col_next = c0 + 1'b1;
            row_next = r0;
        end

        px_a = kind ? mgs3_pkg::DRAIN_VALUE : pixel_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= clamp_dim(mgs3_pkg::WIDTH_RESET, MAXW_C);
            height_reg    <= clamp_dim(mgs3_pkg::HEIGHT_RESET, MAXH_C);
            min_valid_reg <= mgs3_pkg::MIN_VALID_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mgs3_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= clamp_dim(cfg_data, MAXW_C);
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                mgs3_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= clamp_dim(cfg_data, MAXH_C);
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                mgs3_pkg::CFG_MIN_VALID:
                begin
                    min_valid_reg <= cfg_data[mgs3_pkg::MINV_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            col_reg <= col_next[COL_W-1:0];
            row_reg <= row_next[ROW_W-1:0];
        end
    end

    // A read issued in the same cycle as a write to the same column sees old
    // data, so the written word is kept and used instead.
    assign line_word = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_en     = en && s1_valid_reg;
    assign wr_data   = {line_word[mgs3_pkg::PIX_W-1:0], s1_px_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == c0[COL_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= c0[COL_W-1:0];
            s1_px_reg    <= px_a;
            s1_pos_reg   <= pos_a;
            fwd_data_reg <= wr_data;
        end
    end

    mgs3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (mgs3_pkg::LINE_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (c0[COL_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    mgs3_window_sum u_window_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .top       (line_word[mgs3_pkg::LINE_W-1:mgs3_pkg::PIX_W]),
        .mid       (line_word[mgs3_pkg::PIX_W-1:0]),
        .px        (s1_px_reg),
        .pos       (s1_pos_reg),
        .min_valid (min_valid_reg),
        .sum_out   (sum_stage)
    );

    mgs3_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .sum_in (sum_stage),
        .result (scaled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= scaled.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && scaled.valid)
        begin
            value_reg <= scaled.value;
            flag_reg  <= scaled.flag;
            last_reg  <= scaled.last;
        end
    end

    assign result_valid   = result_valid_reg;
    assign filtered_value = value_reg;
    assign missing_flag   = flag_reg;
    assign frame_end      = last_reg;

endmodule

FILE: src/mgs3_checker.sv
// Port-level checks for the smoother, bound to the top level.
module mgs3_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              pixel_stall,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic signed [mgs3_pkg::PIX_W-1:0] filtered_value,
    input logic                              missing_flag,
    input logic                              frame_end
);

    // A stalled result keeps its contents until the transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(filtered_value)
            && $stable(missing_flag) && $stable(frame_end))
        else $error("result changed while stalled");

    // A flagged result always carries the missing-data value.
    a_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && missing_flag |-> filtered_value == mgs3_pkg::MISSING_VALUE)
        else $error("flagged result without missing value");

    // A smoothed value comes only from usable, non-negative pixels.
    a_value_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !missing_flag |-> !filtered_value[mgs3_pkg::PIX_W-1])
        else $error("negative smoothed value");

    // The pipeline holds as a whole while a result waits, so no pixel transfers.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> pixel_stall)
        else $error("pixel taken while result stalled");

endmodule

bind masked_gaussian_3x3_smoother_unit mgs3_checker u_mgs3_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pixel_stall    (pixel_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .filtered_value (filtered_value),
    .missing_flag   (missing_flag),
    .frame_end      (frame_end)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the masked 3x3 Gaussian smoother with a built-in predictor.
module tb_top;

    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int IDLE_PCT       = 34;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                       kind;
        logic [mgs3_pkg::PIX_W-1:0] value;
    } pixel_item_t;

    typedef struct packed {
        logic [mgs3_pkg::PIX_W-1:0] value;
        logic                       flag;
        logic                       last;
    } smooth_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [mgs3_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mgs3_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    logic kind = 1'b0;
    logic signed [mgs3_pkg::PIX_W-1:0] pixel_value = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [mgs3_pkg::PIX_W-1:0] filtered_value;
    logic missing_flag;
    logic frame_end;

    // Stimulus and predictor state.
    pixel_item_t pixel_items[$];
    smooth_out_t expected_pixels[$];
    logic no_idle = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    logic [mgs3_pkg::DIM_W-1:0]  cur_width;
    logic [mgs3_pkg::DIM_W-1:0]  cur_height;
    logic [mgs3_pkg::MINV_W-1:0] cur_min_valid;
    logic [mgs3_pkg::PIX_W-1:0]  line_above [0:MAX_W-1];
    logic [mgs3_pkg::PIX_W-1:0]  line_recent [0:MAX_W-1];
    logic [mgs3_pkg::PIX_W-1:0]  win [0:8];
    int unsigned col_pos;
    int unsigned row_pos;

    masked_gaussian_3x3_smoother_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .kind           (kind),
        .pixel_value    (pixel_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .filtered_value (filtered_value),
        .missing_flag   (missing_flag),
        .frame_end      (frame_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [mgs3_pkg::DIM_W-1:0] v,
                                              input int unsigned hi);
        if (v < mgs3_pkg::MIN_DIM)
            return mgs3_pkg::MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advances the frame position and line stores by one item and queues the
    // smoothed pixel that the item completes, if any.
    task automatic predict_smooth(input logic item_kind,
                                  input logic [mgs3_pkg::PIX_W-1:0] item_bits);
        int unsigned w, h, c, r, rc, cc, sum, n, mv, q, wt;
        int k, dr, dc;
        logic [mgs3_pkg::PIX_W-1:0] px, top, mid, v;
        logic produces;
        smooth_out_t res;
        w = clamp_dim(cur_width, MAX_W);
        h = clamp_dim(cur_height, MAX_H);
        if (col_pos >= w || row_pos > h + 1)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        // A drain item inside the frame reads as a missing pixel.
        px = item_kind ? mgs3_pkg::DRAIN_VALUE : item_bits;
        top = line_above[c];
        mid = line_recent[c];
        line_above[c] = mid;
        line_recent[c] = px;
        for (k = 0; k < 3; k++)
        begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;

        produces = (r >= 2) || (r == 1 && c >= 1);
        rc = 0;
        cc = 0;
        if (produces)
        begin
            if (c == 0)
            begin
                cc = w - 1;
                rc = r - 2;
            end
            else
            begin
                cc = c - 1;
                rc = r - 1;
            end
        end
        if (produces && rc == h - 1 && cc == w - 1)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
            end
        end
        if (produces)
        begin
            sum = 0;
            n = 0;
            for (dr = 0; dr < 3; dr++)
            begin
                for (dc = 0; dc < 3; dc++)
                begin
                    v = win[dr * 3 + dc];
                    if (!((dr == 0 && rc == 0) || (dr == 2 && rc + 1 >= h) ||
                          (dc == 0 && cc == 0) || (dc == 2 && cc + 1 >= w) ||
                          v[mgs3_pkg::PIX_W-1]))
                    begin
                        wt = ((dr == 1) ? 2 : 1) * ((dc == 1) ? 2 : 1);
                        sum = sum + wt * v;
                        n = n + 1;
                    end
                end
            end
            mv = (cur_min_valid == 0) ? 1 : cur_min_valid;
            if (n < mv)
            begin
                res.value = mgs3_pkg::MISSING_VALUE;
                res.flag = 1'b1;
            end
            else
            begin
                q = (sum * 9) / (16 * n);
                if (q > 32767)
                    q = 32767;
                res.value = q[mgs3_pkg::PIX_W-1:0];
                res.flag = 1'b0;
            end
            res.last = (rc == h - 1 && cc == w - 1);
            expected_pixels.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [mgs3_pkg::PIX_W-1:0] got,
                                   input logic [mgs3_pkg::PIX_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Driver: presents queued pixel items and feeds every transfer to the predictor.
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        pixel_item_t next_item;
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            kind <= 1'b0;
            pixel_value <= '0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
                predict_smooth(kind, pixel_value);
            if (!pixel_valid || !pixel_stall)
            begin
                if (pixel_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = pixel_items.pop_front();
                    kind <= next_item.kind;
                    pixel_value <= next_item.value;
                    pixel_valid <= 1'b1;
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        smooth_out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("unexpected result", filtered_value, '0);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (filtered_value !== want.value)
                        report_mismatch("filtered_value", filtered_value, want.value);
                    if (missing_flag !== want.flag)
                        report_mismatch("missing_flag", {15'd0, missing_flag}, {15'd0, want.flag});
                    if (frame_end !== want.last)
                        report_mismatch("frame_end", {15'd0, frame_end}, {15'd0, want.last});
                end
            end
            result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input logic item_kind, input logic [mgs3_pkg::PIX_W-1:0] item_bits);
        pixel_item_t item;
        item.kind = item_kind;
        item.value = item_bits;
        pixel_items.push_back(item);
    endtask

    function automatic logic [mgs3_pkg::PIX_W-1:0] pick_pixel(input int unsigned missing_pct);
        logic [31:0] bits;
        int unsigned roll;
        bits = $urandom;
        roll = $urandom_range(99);
        if (roll < missing_pct)
            return {1'b1, bits[14:0]};
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            case (bits[17:16])
                2'd0:    return 16'h7FFF;
                2'd1:    return 16'h0000;
                2'd2:    return 16'h0001;
                default: return 16'h7FFE;
            endcase
        end
        if (roll < 30)
            return {6'd0, bits[9:0]};
        return {1'b0, bits[14:0]};
    endfunction

    // Queues up to item_limit items of a w x h frame followed by its drain items.
    // A noisy frame carries drain items among its pixels and pixels among its drains.
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input int unsigned missing_pct, input logic noisy,
                               input int unsigned item_limit);
        int unsigned i;
        logic [31:0] bits;
        for (i = 0; i < w * h + w + 1 && i < item_limit; i++)
        begin
            bits = $urandom;
            if (i < w * h)
            begin
                if (noisy && $urandom_range(99) < 3)
                    push_item(1'b1, bits[15:0]);
                else
                    push_item(1'b0, pick_pixel(missing_pct));
            end
            else
            begin
                push_item(!(noisy && $urandom_range(99) < 10), bits[15:0]);
            end
        end
    endtask

    task automatic wait_drained();
        while (pixel_items.size() != 0 || pixel_valid || expected_pixels.size() != 0)
            @(posedge clk);
        // Items that complete no result may still be inside the pipeline.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mgs3_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mgs3_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            mgs3_pkg::CFG_IMAGE_WIDTH:
            begin
                cur_width = data;
                col_pos = 0;
                row_pos = 0;
            end
            mgs3_pkg::CFG_IMAGE_HEIGHT:
            begin
                cur_height = data;
                col_pos = 0;
                row_pos = 0;
            end
            mgs3_pkg::CFG_MIN_VALID:
                cur_min_valid = data[mgs3_pkg::MINV_W-1:0];
            default:
                ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned items_sent, w, h, missing_pct, frames, f, partial;
        logic restart_due;
        logic [mgs3_pkg::CFG_DATA_W-1:0] data;
        logic [31:0] bits;

        cur_width = mgs3_pkg::WIDTH_RESET;
        cur_height = mgs3_pkg::HEIGHT_RESET;
        cur_min_valid = mgs3_pkg::MIN_VALID_RESET;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < MAX_W; i++)
        begin
            line_above[i] = '0;
            line_recent[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame with edge values, a drain inside the frame and a pixel
        // among the drain items; one result saturates.
        write_reg(mgs3_pkg::CFG_IMAGE_WIDTH, 11'd3);
        write_reg(mgs3_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        write_reg(mgs3_pkg::CFG_MIN_VALID, 11'd1);
        push_item(1'b0, 16'h8000);
        push_item(1'b0, 16'hFFFF);
        push_item(1'b0, 16'h0000);
        push_item(1'b0, 16'h0001);
        push_item(1'b0, 16'h7FFF);
        push_item(1'b1, 16'h0000);
        push_item(1'b0, 16'h7FFF);
        push_item(1'b0, 16'h7FFE);
        push_item(1'b0, 16'hFF00);
        push_item(1'b1, 16'hFFFF);
        push_item(1'b0, 16'h1234);
        push_item(1'b1, 16'h0000);
        push_item(1'b1, 16'h7FFF);
        wait_drained();

        // Undersized width and height clamp to three; a zero threshold acts as one.
        write_reg(mgs3_pkg::CFG_IMAGE_WIDTH, 11'd0);
        write_reg(mgs3_pkg::CFG_IMAGE_HEIGHT, 11'd1);
        write_reg(mgs3_pkg::CFG_MIN_VALID, 11'h7F0);
        push_item(1'b0, 16'h7FFF);
        push_item(1'b0, 16'h8000);
        push_item(1'b0, 16'h7FFF);
        push_item(1'b0, 16'h8000);
        push_item(1'b0, 16'h8000);
        push_item(1'b0, 16'h8000);
        push_item(1'b0, 16'h7FFF);
        push_item(1'b0, 16'h8000);
        push_item(1'b0, 16'h0001);
        push_item(1'b1, 16'h0000);
        push_item(1'b1, 16'h0000);
        push_item(1'b1, 16'h0000);
        push_item(1'b1, 16'h0000);
        wait_drained();

        // A whole frame with no idling on either side.
        no_idle <= 1'b1;
        write_reg(mgs3_pkg::CFG_IMAGE_WIDTH, 11'd12);
        write_reg(mgs3_pkg::CFG_IMAGE_HEIGHT, 11'd10);
        write_reg(mgs3_pkg::CFG_MIN_VALID, 11'd3);
        queue_frame(12, 10, 15, 1'b0, 12 * 10 + 12 + 1);
        wait_drained();
        no_idle <= 1'b0;

        items_sent = 0;
        restart_due = 1'b0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (restart_due || $urandom_range(99) < 70)
            begin
                bits = $urandom_range(99);
                if (bits < 80)
                    data = mgs3_pkg::CFG_DATA_W'($urandom_range(12, 3));
                else if (bits < 90)
                    data = mgs3_pkg::CFG_DATA_W'($urandom_range(2, 0));
                else
                    data = mgs3_pkg::CFG_DATA_W'($urandom_range(40, 13));
                write_reg(mgs3_pkg::CFG_IMAGE_WIDTH, data);
            end
            if ($urandom_range(99) < 70)
            begin
                bits = $urandom_range(99);
                if (bits < 85)
                    data = mgs3_pkg::CFG_DATA_W'($urandom_range(8, 3));
                else
                    data = mgs3_pkg::CFG_DATA_W'($urandom_range(2, 0));
                write_reg(mgs3_pkg::CFG_IMAGE_HEIGHT, data);
            end
            if ($urandom_range(99) < 70)
            begin
                data = mgs3_pkg::CFG_DATA_W'($urandom);
                if ($urandom_range(99) < 25)
                    data[mgs3_pkg::MINV_W-1:0] = mgs3_pkg::MINV_W'($urandom_range(15, 10));
                else
                    data[mgs3_pkg::MINV_W-1:0] = mgs3_pkg::MINV_W'($urandom_range(9, 0));
                write_reg(mgs3_pkg::CFG_MIN_VALID, data);
            end
            w = clamp_dim(cur_width, MAX_W);
            h = clamp_dim(cur_height, MAX_H);
            missing_pct = $urandom_range(60);
            frames = $urandom_range(3, 1);
            for (f = 0; f < frames; f++)
            begin
                queue_frame(w, h, missing_pct, $urandom_range(99) < 25, w * h + w + 1);
                items_sent = items_sent + w * h + w + 1;
            end
            // Now and then a frame is cut short; the next phase restarts the position.
            restart_due = 1'b0;
            if ($urandom_range(99) < 15)
            begin
                partial = $urandom_range(w * h + w, 1);
                queue_frame(w, h, missing_pct, 1'b0, partial);
                items_sent = items_sent + partial;
                restart_due = 1'b1;
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: masked_gaussian_3x3_smoother_unit.f
src/mgs3_pkg.sv
src/mgs3_line_store.sv
src/mgs3_window_sum.sv
src/mgs3_scale.sv
src/masked_gaussian_3x3_smoother_unit.sv
src/mgs3_checker.sv
tb/sv/tb_top.sv
